[rtl/scx_pkg.sv]
// Shared types, constants and codes of the stack calculator executor.
`timescale 1ns / 1ps
package scx_pkg;
    localparam int STACK_DEPTH = 128;
    localparam int PTR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0, ACT_SUB = 3'd1, ACT_MUL = 3'd2, ACT_DIV = 3'd3,
        ACT_PUSH = 3'd4, ACT_POP = 3'd5, ACT_EXIT = 3'd6, ACT_NOP = 3'd7
    } action_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_UNDER = 3'd1, ST_OVER = 3'd2, ST_DIVZ = 3'd3, ST_DEPTH = 3'd4
    } status_t;

    // one decoded instruction handed from the front end to the back end
    typedef struct packed {
        action_t     action;
        logic [63:0] immediate;
    } instr_t;

    typedef enum logic [3:0] {
        BE_IDLE, BE_RD1, BE_LOAD, BE_MUL, BE_DIV, BE_WRITE, BE_EXIT_RD,
        BE_EXIT_WAIT, BE_OUT
    } be_state_t;
endpackage

[rtl/scx_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module scx_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and read in the same cycle; read returns old data
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

[rtl/scx_front.sv]
// Front end: accepts instructions, drops unused codes, and queues them.
`timescale 1ns / 1ps
module scx_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [71:0]            s_tdata,
    output logic                   q_valid,
    input  logic                   q_ready,
    output scx_pkg::instr_t        q_data
);
    import scx_pkg::*;

    localparam int QP_W = $clog2(QUEUE_DEPTH);

    instr_t             slot_reg [QUEUE_DEPTH];
    logic [QP_W-1:0]    wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [QP_W:0]      fill_reg, fill_next;
    logic               push, pop;
    instr_t             in_instr;

    assign in_instr.action    = action_t'(s_tdata[2:0]);
    assign in_instr.immediate = s_tdata[66:3];
    assign s_tready = (fill_reg != (QP_W+1)'(QUEUE_DEPTH));
    // drop the unused code at the door
    assign push    = s_tvalid && s_tready && (in_instr.action != ACT_NOP);
    assign q_valid = (fill_reg != '0);
    assign pop     = q_valid && q_ready;
    assign q_data  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + (QP_W+1)'(push) - (QP_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_instr;
        end
    end

    property p_no_overfill;
        @(posedge aclk) disable iff (!aresetn) fill_reg <= (QP_W+1)'(QUEUE_DEPTH);
    endproperty
    a_no_overfill: assert property (p_no_overfill) else $error("queue overfilled");

    property p_empty_no_pop;
        @(posedge aclk) disable iff (!aresetn) (fill_reg == '0) |-> !pop;
    endproperty
    a_empty_no_pop: assert property (p_empty_no_pop) else $error("pop from empty queue");

    property p_fill_tracks;
        @(posedge aclk) disable iff (!aresetn)
            (push && !pop) |=> (fill_reg == $past(fill_reg) + 1'b1);
    endproperty
    a_fill_tracks: assert property (p_fill_tracks) else $error("fill count slip");
endmodule

[rtl/scx_back.sv]
// Back end: stack memory, ALU with iterative multiply and divide, result register.
`timescale 1ns / 1ps
module scx_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  scx_pkg::instr_t        q_data,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [71:0]            m_tdata
);
    import scx_pkg::*;

    be_state_t          state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    instr_t             cur_reg, cur_next;
    logic [63:0]        a_reg, a_next, b_reg, b_next;
    logic [63:0]        acc_reg, acc_next;
    logic [63:0]        rem_reg, rem_next;
    logic [6:0]         iter_reg, iter_next;
    logic               neg_reg, neg_next;
    logic [63:0]        res_val_reg, res_val_next;
    status_t            res_st_reg, res_st_next;
    logic               out_valid_reg, out_valid_next;
    status_t            pend_st_reg, pend_st_next;
    logic [63:0]        pend_val_reg, pend_val_next;

    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr, rd_addr;
    logic [63:0]        wr_data, rd_data;
    logic [64:0]        trial;
    logic [63:0]        rem_sh;

    scx_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_stack (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, res_st_reg, res_val_reg};

    // one restoring division step
    assign rem_sh = {rem_reg[62:0], acc_reg[63]};
    assign trial  = {1'b0, rem_sh} - {1'b0, b_reg};

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        iter_next      = iter_reg;
        neg_next       = neg_reg;
        res_val_next   = res_val_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg;
        pend_st_next   = pend_st_reg;
        pend_val_next  = pend_val_reg;
        q_ready        = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = count_reg[PTR_W-1:0];
        wr_data        = q_data.immediate;
        rd_addr        = '0;
        // drop the result once taken
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            BE_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    cur_next = q_data;
                    case (q_data.action)
                        ACT_PUSH: begin
                            if (count_reg == CNT_W'(STACK_DEPTH)) begin
                                pend_st_next = ST_OVER;
                                state_next   = BE_OUT;
                            end else begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        ACT_POP: begin
                            if (count_reg == '0) begin
                                pend_st_next = ST_UNDER;
                                state_next   = BE_OUT;
                            end else begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        ACT_EXIT: begin
                            if (count_reg != CNT_W'(1)) begin
                                pend_st_next = ST_DEPTH;
                                state_next   = BE_OUT;
                            end else begin
                                state_next = BE_EXIT_RD;
                            end
                        end
                        ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: begin
                            if (count_reg < CNT_W'(2)) begin
                                pend_st_next = ST_UNDER;
                                state_next   = BE_OUT;
                            end else begin
                                rd_addr    = PTR_W'(count_reg - 1'b1);
                                state_next = BE_RD1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BE_RD1: begin
                // top entry is back; fetch the one below it
                b_next     = rd_data;
                rd_addr    = PTR_W'(count_reg - CNT_W'(2));
                state_next = BE_LOAD;
            end
            BE_LOAD: begin
                a_next = rd_data;
                case (cur_reg.action)
                    ACT_ADD: begin
                        acc_next   = rd_data + b_reg;
                        state_next = BE_WRITE;
                    end
                    ACT_SUB: begin
                        acc_next   = rd_data - b_reg;
                        state_next = BE_WRITE;
                    end
                    ACT_MUL: begin
                        acc_next   = '0;
                        iter_next  = '0;
                        state_next = BE_MUL;
                    end
                    default: begin
                        if (b_reg == '0) begin
                            pend_st_next = ST_DIVZ;
                            state_next   = BE_OUT;
                        end else begin
                            neg_next   = rd_data[63] ^ b_reg[63];
                            acc_next   = rd_data[63] ? -rd_data : rd_data;
                            b_next     = b_reg[63] ? -b_reg : b_reg;
                            rem_next   = '0;
                            iter_next  = '0;
                            state_next = BE_DIV;
                        end
                    end
                endcase
            end
            BE_MUL: begin
                // shift-add, one multiplier bit a cycle
                acc_next  = acc_reg + (b_reg[0] ? a_reg : 64'd0);
                a_next    = {a_reg[62:0], 1'b0};
                b_next    = {1'b0, b_reg[63:1]};
                iter_next = iter_reg + 1'b1;
                if (iter_reg == 7'd63) begin
                    state_next = BE_WRITE;
                end
            end
            BE_DIV: begin
                if (!trial[64]) begin
                    rem_next = trial[63:0];
                end else begin
                    rem_next = rem_sh;
                end
                acc_next  = {acc_reg[62:0], ~trial[64]};
                iter_next = iter_reg + 1'b1;
                if (iter_reg == 7'd63) begin
                    if (neg_reg) begin
                        acc_next = -{acc_reg[62:0], ~trial[64]};
                    end
                    state_next = BE_WRITE;
                end
            end
            BE_WRITE: begin
                wr_en      = 1'b1;
                wr_addr    = PTR_W'(count_reg - CNT_W'(2));
                wr_data    = acc_reg;
                count_next = count_reg - 1'b1;
                state_next = BE_IDLE;
            end
            BE_EXIT_RD: begin
                rd_addr    = '0;
                state_next = BE_EXIT_WAIT;
            end
            BE_EXIT_WAIT: begin
                if (!out_valid_next) begin
                    res_st_next    = ST_OK;
                    res_val_next   = rd_data;
                    out_valid_next = 1'b1;
                    count_next     = '0;
                    state_next     = BE_IDLE;
                end else begin
                    // park the value until the output register frees up
                    pend_st_next  = ST_OK;
                    pend_val_next = rd_data;
                    state_next    = BE_OUT;
                end
            end
            BE_OUT: begin
                // hold until the output register is free
                if (!out_valid_next) begin
                    res_st_next    = pend_st_reg;
                    res_val_next   = (pend_st_reg == ST_OK) ? pend_val_reg : '0;
                    out_valid_next = 1'b1;
                    count_next     = '0;
                    state_next     = BE_IDLE;
                end
            end
            default: state_next = BE_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BE_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        iter_reg     <= iter_next;
        neg_reg      <= neg_next;
        res_val_reg  <= res_val_next;
        res_st_reg   <= res_st_next;
        pend_st_reg  <= pend_st_next;
        pend_val_reg <= pend_val_next;
    end

    property p_count_bound;
        @(posedge aclk) disable iff (!aresetn) count_reg <= CNT_W'(STACK_DEPTH);
    endproperty
    a_count_bound: assert property (p_count_bound) else $error("stack count out of range");

    property p_result_clears;
        @(posedge aclk) disable iff (!aresetn)
            (!out_valid_reg && out_valid_next) |=> (count_reg == '0);
    endproperty
    a_result_clears: assert property (p_result_clears) else $error("stack not cleared");

    property p_error_zero;
        @(posedge aclk) disable iff (!aresetn)
            (out_valid_reg && res_st_reg != ST_OK) |-> (res_val_reg == '0);
    endproperty
    a_error_zero: assert property (p_error_zero) else $error("error result carries value");
endmodule

[rtl/stack_calculator_executor.sv]
// Top level of the stack calculator executor: front end, queue, back end.
// Push and pop retire from idle; add and sub read both entries, then write; exit reads then outputs.
// Mul and div run a 64-step shift loop in the back end between the reads and the write.
// Most errors are reported straight from idle, divide by zero once both entries are read;
// every result empties the stack.
// A two-entry queue lets the front keep accepting while the back end works.
// Synchronous active-low reset empties the stack, the queue and the output.
`timescale 1ns / 1ps
module stack_calculator_executor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [2:0] action, [66:3] immediate
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [63:0] value, [66:64] status
);
    import scx_pkg::*;

    logic   q_valid, q_ready;
    instr_t q_data;

    scx_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    scx_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_data(q_data), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );
endmodule

[sim/scx_checker.sv]
// Checker for the stack calculator executor: predicts results and compares transfers.
`timescale 1ns / 1ps
module scx_checker
    import scx_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    output int          fail_count,
    output int          pending_count,
    output int          result_count
);
    typedef struct packed {
        status_t     status;
        logic [63:0] value;
    } calc_result_t;

    logic [63:0]  calc_stack [STACK_DEPTH];
    int           calc_depth;
    calc_result_t expected_results [$];

    // Signed divide truncating toward zero; wraps for most-negative by -1.
    function automatic logic [63:0] quotient_of(logic [63:0] n, logic [63:0] d);
        logic [63:0] mn, md, q;
        mn = n[63] ? -n : n;
        md = d[63] ? -d : d;
        q = mn / md;
        return (n[63] != d[63]) ? -q : q;
    endfunction

    task automatic post_result(status_t st, logic [63:0] val);
        calc_result_t r;
        r.status = st;
        r.value = val;
        expected_results.push_back(r);
        calc_depth = 0;
    endtask

    // Apply one accepted instruction to the predicted stack.
    task automatic execute_instr(action_t act, logic [63:0] imm);
        logic [63:0] a, b, r;
        case (act)
            ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: begin
                if (calc_depth < 2) begin
                    post_result(ST_UNDER, '0);
                end else begin
                    b = calc_stack[calc_depth - 1];
                    a = calc_stack[calc_depth - 2];
                    if (act == ACT_DIV && b == '0) begin
                        post_result(ST_DIVZ, '0);
                    end else begin
                        case (act)
                            ACT_ADD: r = a + b;
                            ACT_SUB: r = a - b;
                            ACT_MUL: r = a * b;
                            default: r = quotient_of(a, b);
                        endcase
                        calc_depth = calc_depth - 1;
                        calc_stack[calc_depth - 1] = r;
                    end
                end
            end
            ACT_PUSH: begin
                if (calc_depth >= STACK_DEPTH) begin
                    post_result(ST_OVER, '0);
                end else begin
                    calc_stack[calc_depth] = imm;
                    calc_depth = calc_depth + 1;
                end
            end
            ACT_POP: begin
                if (calc_depth == 0) post_result(ST_UNDER, '0);
                else calc_depth = calc_depth - 1;
            end
            ACT_EXIT: begin
                if (calc_depth != 1) post_result(ST_DEPTH, '0);
                else post_result(ST_OK, calc_stack[0]);
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        fail_count = fail_count + 1;
    endtask

    initial begin
        fail_count = 0;
        calc_depth = 0;
        result_count = 0;
    end

    // Compare each result transfer, then predict from each input transfer.
    always @(posedge aclk) begin
        calc_result_t want;
        if (!aresetn) begin
            calc_depth = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                result_count = result_count + 1;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata[63:0], '0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[63:0] !== want.value)
                        report_mismatch("value", m_tdata[63:0], want.value);
                    if (m_tdata[66:64] !== want.status)
                        report_mismatch("status", 64'(m_tdata[66:64]), 64'(want.status));
                end
            end
            if (s_tvalid && s_tready)
                execute_instr(action_t'(s_tdata[2:0]), s_tdata[66:3]);
        end
        pending_count = expected_results.size();
    end
endmodule

[sim/testbench.sv]
// Top of the stack calculator executor testbench: stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
    import scx_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    int          fail_count, pending_count, result_count;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          idle_cycles = 0;
    int          instr_count = 0;

    always #1 aclk = ~aclk;

    stack_calculator_executor dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    scx_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count)
    );

    // Stall the result side at random.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: count cycles with no transfer on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired at %0t", $time);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Drive one instruction and hold it until its transfer; valid stays up
    // after the transfer until the next instruction or an idle cycle.
    task automatic send_instr(action_t act, logic [63:0] imm);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, imm, act};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        instr_count = instr_count + 1;
    endtask

    function automatic logic [63:0] random_word();
        case ($urandom_range(5))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7FFF_FFFF_FFFF_FFFF;
            2: return 64'(signed'($urandom_range(6)) - 3);
            3: return {$urandom, $urandom} >> $urandom_range(63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly well-formed programs with random values; some malformed ones.
    task automatic send_program();
        int depth, len;
        action_t act;
        depth = 0;
        len = $urandom_range(12, 1);
        for (int i = 0; i < len; i++) begin
            if (depth < 2 || $urandom_range(2) == 0) begin
                send_instr(ACT_PUSH, random_word());
                depth++;
            end else begin
                act = action_t'($urandom_range(3));
                send_instr(act, random_word());
                depth--;
            end
        end
        while (depth > 1 && $urandom_range(3) != 0) begin
            send_instr(action_t'($urandom_range(3)), random_word());
            depth--;
        end
        case ($urandom_range(9))
            0: send_instr(ACT_POP, random_word());
            1: send_instr(ACT_NOP, random_word());
            2: send_instr(action_t'($urandom_range(7)), random_word());
            default: ;
        endcase
        send_instr(ACT_EXIT, random_word());
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: every action, error case and field extreme.
        send_instr(ACT_ADD, '0);
        send_instr(ACT_POP, '1);
        send_instr(ACT_EXIT, '0);
        send_instr(ACT_PUSH, 64'h8000_0000_0000_0000);
        send_instr(ACT_PUSH, '1);
        send_instr(ACT_DIV, '0);
        send_instr(ACT_EXIT, '0);
        send_instr(ACT_PUSH, 64'h7FFF_FFFF_FFFF_FFFF);
        send_instr(ACT_PUSH, 64'h7FFF_FFFF_FFFF_FFFF);
        send_instr(ACT_MUL, '0);
        send_instr(ACT_PUSH, 64'd3);
        send_instr(ACT_ADD, '0);
        send_instr(ACT_PUSH, '0);
        send_instr(ACT_DIV, '0);
        send_instr(ACT_PUSH, -64'sd7);
        send_instr(ACT_PUSH, 64'd2);
        send_instr(ACT_DIV, '0);
        send_instr(ACT_NOP, '1);
        send_instr(ACT_PUSH, 64'd5);
        send_instr(ACT_SUB, '0);
        send_instr(ACT_EXIT, '0);
        send_instr(ACT_PUSH, 64'd1);
        send_instr(ACT_PUSH, 64'd1);
        send_instr(ACT_EXIT, '0);
        // Fill the stack past its depth to hit overflow.
        for (int i = 0; i <= STACK_DEPTH; i++) send_instr(ACT_PUSH, 64'(i));
        send_instr(ACT_EXIT, '0);
        wait_drained();

        // Random programs under several idle patterns.
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 74 : 33) : 0;
            recv_stall_pct = (phase == 2) ? 74 : (phase == 3 ? 33 : 0);
            for (int p = 0; p < 45; p++) send_program();
            wait_drained();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();

        $display("covered %0d instructions and %0d results over four idle patterns,",
                 instr_count, result_count);
        $display("including underflow, overflow, divide by zero and bad exit depth");
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

[stack_calculator_executor.f]
rtl/scx_pkg.sv
rtl/scx_ram.sv
rtl/scx_front.sv
rtl/scx_back.sv
rtl/stack_calculator_executor.sv
sim/scx_checker.sv
sim/testbench.sv
